>>> design/mcss_pkg.sv
// Shared types, constants and the microprogram of the Markov chain state sampler.
package mcss_pkg;

    // Table geometry and number formats
    localparam int MAX_STATES = 16;
    localparam int PROB_BITS  = 16;
    localparam int STATE_W    = $clog2(MAX_STATES);
    localparam int CNT_W      = $clog2(MAX_STATES + 1);
    localparam int ADDR_W     = 2 * STATE_W;
    localparam int ACC_W      = PROB_BITS + 1;
    localparam int CFG_W      = 5;
    localparam int OP_W       = 2;
    localparam int UPC_W      = 4;
    localparam int ROM_DEPTH  = 1 << UPC_W;

    // Saturation level of the running sum: 1.0
    localparam logic [ACC_W-1:0] PROB_ONE = ACC_W'(1) << PROB_BITS;

    typedef logic [STATE_W-1:0] t_state;
    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [UPC_W-1:0]   t_upc;

    // Item opcodes; code 3 is unused and handled as a no-op
    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_SET   = 2'd1,
        OP_STEP  = 2'd2
    } t_op;

    // Jump conditions of a microword
    typedef enum logic [2:0] {
        C_ALWAYS   = 3'd0,
        C_NO_INPUT = 3'd1,
        C_OP_WRITE = 3'd2,
        C_OP_SET   = 3'd3,
        C_NOT_STEP = 3'd4,
        C_NOT_DONE = 3'd5,
        C_OUT_BUSY = 3'd6
    } t_cond;

    // Datapath control, one bit per action
    typedef struct packed {
        logic accept;     // input channel open, latch fields on transfer
        logic wr_table;   // store latched probability
        logic set_state;  // force state if in range
        logic clr_walk;   // clear sum and column
        logic walk;       // add one entry, advance column, pick when done
        logic emit;       // load output register when free
    } t_ctrl;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic op_write;
        logic op_set;
        logic op_step;
        logic done;
        logic out_busy;
    } t_stat;

    typedef struct packed {
        t_cond cond;
        t_upc  target;
        t_ctrl ctrl;
    } t_uword;

    // Microprogram addresses
    localparam t_upc A_FETCH = 4'd0;
    localparam t_upc A_DEC_W = 4'd1;
    localparam t_upc A_DEC_S = 4'd2;
    localparam t_upc A_DEC_O = 4'd3;
    localparam t_upc A_START = 4'd4;
    localparam t_upc A_WALK  = 4'd5;
    localparam t_upc A_EMIT  = 4'd6;
    localparam t_upc A_RET   = 4'd7;
    localparam t_upc A_WRITE = 4'd8;
    localparam t_upc A_SET   = 4'd9;

    // Clamp register value to 1..MAX_STATES
    function automatic t_cnt clamp_states(input logic [CFG_W-1:0] v);
        t_cnt r;
        if (v == '0) begin
            r = CNT_W'(1);
        end else if (CNT_W'(v) > CNT_W'(MAX_STATES)) begin
            r = CNT_W'(MAX_STATES);
        end else begin
            r = CNT_W'(v);
        end
        return r;
    endfunction

    // Control store: a jump is taken when cond holds, else upc+1
    function automatic t_uword ucode(input t_upc a);
        t_uword w;
        w        = '0;
        w.cond   = C_ALWAYS;
        w.target = A_FETCH;
        case (a)
            A_FETCH: begin
                w.cond        = C_NO_INPUT;
                w.target      = A_FETCH;
                w.ctrl.accept = 1'b1;
            end
            A_DEC_W: begin
                w.cond   = C_OP_WRITE;
                w.target = A_WRITE;
            end
            A_DEC_S: begin
                w.cond   = C_OP_SET;
                w.target = A_SET;
            end
            A_DEC_O: begin
                w.cond   = C_NOT_STEP;
                w.target = A_EMIT;
            end
            A_START: begin
                w.cond          = C_ALWAYS;
                w.target        = A_WALK;
                w.ctrl.clr_walk = 1'b1;
            end
            A_WALK: begin
                w.cond      = C_NOT_DONE;
                w.target    = A_WALK;
                w.ctrl.walk = 1'b1;
            end
            A_EMIT: begin
                w.cond      = C_OUT_BUSY;
                w.target    = A_EMIT;
                w.ctrl.emit = 1'b1;
            end
            A_RET: begin
                w.cond   = C_ALWAYS;
                w.target = A_FETCH;
            end
            A_WRITE: begin
                w.cond          = C_ALWAYS;
                w.target        = A_EMIT;
                w.ctrl.wr_table = 1'b1;
            end
            A_SET: begin
                w.cond           = C_ALWAYS;
                w.target         = A_EMIT;
                w.ctrl.set_state = 1'b1;
            end
            default: begin
                w.cond   = C_ALWAYS;
                w.target = A_FETCH;
            end
        endcase
        return w;
    endfunction

endpackage

>>> design/mcss_sequencer.sv
// Microprogram sequencer: step counter, control store lookup and conditional jumps.
module mcss_sequencer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  mcss_pkg::t_stat i_stat,
    output mcss_pkg::t_ctrl o_ctrl
);

    mcss_pkg::t_upc   r_upc;
    mcss_pkg::t_upc   n_upc;
    mcss_pkg::t_uword uw;
    logic             take;

    // Control word of the current step
    always_comb begin
        uw     = mcss_pkg::ucode(r_upc);
        o_ctrl = uw.ctrl;
    end

    // Jump condition
    always_comb begin
        case (uw.cond)
            mcss_pkg::C_ALWAYS:   take = 1'b1;
            mcss_pkg::C_NO_INPUT: take = !i_in_valid;
            mcss_pkg::C_OP_WRITE: take = i_stat.op_write;
            mcss_pkg::C_OP_SET:   take = i_stat.op_set;
            mcss_pkg::C_NOT_STEP: take = !i_stat.op_step;
            mcss_pkg::C_NOT_DONE: take = !i_stat.done;
            mcss_pkg::C_OUT_BUSY: take = i_stat.out_busy;
            default:              take = 1'b1;
        endcase
    end

    // Next step
    always_comb begin
        n_upc = take ? uw.target : r_upc + mcss_pkg::t_upc'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= mcss_pkg::A_FETCH;
        end else begin
            r_upc <= n_upc;
        end
    end

`ifndef SYNTHESIS
    // a transfer always enters decode next
    a_fetch_to_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upc == mcss_pkg::A_FETCH && i_in_valid) |=> (r_upc == mcss_pkg::A_DEC_W))
        else $error("sequencer skipped decode after input transfer");
`endif

endmodule

>>> design/mcss_datapath.sv
// Datapath: input latch, transition table memory, running sum, chain state and output register.
module mcss_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mcss_pkg::t_ctrl                   i_ctrl,
    output mcss_pkg::t_stat                   o_stat,
    input  logic                              i_in_valid,
    input  logic [mcss_pkg::OP_W-1:0]         i_op,
    input  logic [mcss_pkg::STATE_W-1:0]      i_from_state,
    input  logic [mcss_pkg::STATE_W-1:0]      i_to_state,
    input  logic [mcss_pkg::PROB_BITS-1:0]    i_probability,
    input  logic [mcss_pkg::PROB_BITS-1:0]    i_random_value,
    input  logic                              i_cfg_valid,
    input  logic [mcss_pkg::CFG_W-1:0]        i_cfg_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [mcss_pkg::STATE_W-1:0]      o_current_state
);

    // Latched item
    logic [mcss_pkg::OP_W-1:0]      r_op;
    mcss_pkg::t_state               r_from;
    mcss_pkg::t_state               r_to;
    logic [mcss_pkg::PROB_BITS-1:0] r_prob;
    logic [mcss_pkg::PROB_BITS-1:0] r_rv;

    // Table memory
    logic [mcss_pkg::PROB_BITS-1:0] r_table [mcss_pkg::MAX_STATES * mcss_pkg::MAX_STATES];
    logic [mcss_pkg::PROB_BITS-1:0] r_rdata;
    logic [mcss_pkg::ADDR_W-1:0]    rd_addr;

    // Walk and chain state
    mcss_pkg::t_cnt             r_n;
    mcss_pkg::t_state           r_state;
    mcss_pkg::t_state           n_state;
    mcss_pkg::t_state           r_col;
    mcss_pkg::t_state           n_col;
    logic [mcss_pkg::ACC_W-1:0] r_acc;
    logic [mcss_pkg::ACC_W-1:0] n_acc;
    logic [mcss_pkg::ACC_W:0]   sum_raw;
    logic [mcss_pkg::ACC_W-1:0] sum_sat;
    mcss_pkg::t_cnt             last_n;
    logic                       hit;
    logic                       last;

    logic                       r_out_valid;
    mcss_pkg::t_state           r_out_state;
    logic                       out_free;

    // Input latch on transfer
    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept && i_in_valid) begin
            r_op   <= i_op;
            r_from <= i_from_state;
            r_to   <= i_to_state;
            r_prob <= i_probability;
            r_rv   <= i_random_value;
        end
    end

    // States in use, stored already clamped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= mcss_pkg::CNT_W'(mcss_pkg::MAX_STATES);
        end else if (i_cfg_valid) begin
            r_n <= mcss_pkg::clamp_states(i_cfg_data);
        end
    end

    // Column counter; memory reads the entry of the next column
    always_comb begin
        if (i_ctrl.clr_walk) begin
            n_col = '0;
        end else if (i_ctrl.walk) begin
            n_col = r_col + mcss_pkg::t_state'(1);
        end else begin
            n_col = r_col;
        end
        rd_addr = {r_state, n_col};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_table) begin
            r_table[{r_from, r_to}] <= r_prob;
        end
        r_rdata <= r_table[rd_addr];
    end

    // Saturating running sum and first-exceeding test
    always_comb begin
        sum_raw = {1'b0, r_acc} + (mcss_pkg::ACC_W + 1)'(r_rdata);
        if (sum_raw > (mcss_pkg::ACC_W + 1)'(mcss_pkg::PROB_ONE)) begin
            sum_sat = mcss_pkg::PROB_ONE;
        end else begin
            sum_sat = sum_raw[mcss_pkg::ACC_W-1:0];
        end
        hit    = sum_sat > mcss_pkg::ACC_W'(r_rv);
        last_n = r_n - mcss_pkg::t_cnt'(1);
        last   = mcss_pkg::t_cnt'(r_col) == last_n;
    end

    // Sum and chain state updates
    always_comb begin
        n_acc   = r_acc;
        n_state = r_state;
        if (i_ctrl.clr_walk) begin
            n_acc = '0;
        end else if (i_ctrl.walk) begin
            n_acc = sum_sat;
            if (hit) begin
                n_state = r_col;
            end else if (last) begin
                n_state = last_n[mcss_pkg::STATE_W-1:0];
            end
        end
        if (i_ctrl.set_state && (mcss_pkg::t_cnt'(r_from) < r_n)) begin
            n_state = r_from;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_col <= n_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else begin
            r_state <= n_state;
        end
    end

    // Output register
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.emit && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.emit && out_free) begin
            r_out_state <= r_state;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_current_state = r_out_state;

    // Status to sequencer
    always_comb begin
        o_stat.op_write = r_op == mcss_pkg::OP_WRITE;
        o_stat.op_set   = r_op == mcss_pkg::OP_SET;
        o_stat.op_step  = r_op == mcss_pkg::OP_STEP;
        o_stat.done     = hit || last;
        o_stat.out_busy = !out_free;
    end

`ifndef SYNTHESIS
    a_n_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_n != '0) && (r_n <= mcss_pkg::CNT_W'(mcss_pkg::MAX_STATES)))
        else $error("states in use out of range");

    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.walk |-> (mcss_pkg::t_cnt'(r_col) < r_n))
        else $error("walk ran past last column in use");

    a_pick_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.walk && o_stat.done) |=> (mcss_pkg::t_cnt'(r_state) < r_n))
        else $error("picked state not in use");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.emit && out_free) |=> r_out_valid)
        else $error("emitted result not presented");
`endif

endmodule

>>> design/markov_chain_state_sampler.sv
// Top level of the Markov chain state sampler: sequencer plus datapath.
//
// Input channel (i_in_valid / o_in_stall) carries one item per transfer:
//   op 0 writes probability into table[from_state][to_state],
//   op 1 forces the chain state to from_state if it is below states in use,
//   op 2 draws the next state by inverse CDF over the current row,
//   op 3 does nothing. Every item returns one result: the chain state after it.
// Output channel (o_out_valid / i_out_stall) presents the result from a
// register; a new item is taken while that result still waits.
// Config channel (i_cfg_valid / o_cfg_ready) writes states in use, always
// ready; write it only while the block is idle. 0 acts as 1, above 16 as 16.
// A write presents its result soonest, a set or no-op later and a step later
// still, the more so the further the column picked (at most states in use - 1),
// because the walk adds one table entry per cycle from a single-port read. After
// a result is loaded the sequencer passes its return step back to fetch; no new
// item is taken before the result of the last one has been loaded.
// A stalled output holds the sequencer at its emit step and the input stays
// stalled. Synchronous reset clears the chain state to 0 and states in use
// to 16; the table is not cleared and must be written before it is walked.
module markov_chain_state_sampler (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [mcss_pkg::OP_W-1:0]      i_op,
    input  logic [mcss_pkg::STATE_W-1:0]   i_from_state,
    input  logic [mcss_pkg::STATE_W-1:0]   i_to_state,
    input  logic [mcss_pkg::PROB_BITS-1:0] i_probability,
    input  logic [mcss_pkg::PROB_BITS-1:0] i_random_value,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [mcss_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [mcss_pkg::STATE_W-1:0]   o_current_state
);

    mcss_pkg::t_ctrl ctrl;
    mcss_pkg::t_stat stat;

    assign o_in_stall  = !ctrl.accept;
    assign o_cfg_ready = 1'b1;

    mcss_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_ctrl     (ctrl)
    );

    mcss_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (ctrl),
        .o_stat          (stat),
        .i_in_valid      (i_in_valid),
        .i_op            (i_op),
        .i_from_state    (i_from_state),
        .i_to_state      (i_to_state),
        .i_probability   (i_probability),
        .i_random_value  (i_random_value),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_current_state (o_current_state)
    );

endmodule

>>> tb/tb.sv
// Self-checking testbench for the Markov chain state sampler: directed and random item streams.
`timescale 1ns / 100ps

module tb;

    // Unused opcode, handled by the block as a no-op
    localparam logic [mcss_pkg::OP_W-1:0] OP_NOP = 2'd3;
    localparam int PROB_FULL = 1 << mcss_pkg::PROB_BITS;   // 1.0
    localparam int PROB_MAX  = PROB_FULL - 1;

    typedef struct {
        logic [mcss_pkg::OP_W-1:0]      op;
        mcss_pkg::t_state               row;
        mcss_pkg::t_state               col;
        logic [mcss_pkg::PROB_BITS-1:0] prob;
        logic [mcss_pkg::PROB_BITS-1:0] rv;
    } t_item;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_in_valid;
    logic                           o_in_stall;
    logic [mcss_pkg::OP_W-1:0]      i_op;
    mcss_pkg::t_state               i_from_state;
    mcss_pkg::t_state               i_to_state;
    logic [mcss_pkg::PROB_BITS-1:0] i_probability;
    logic [mcss_pkg::PROB_BITS-1:0] i_random_value;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [mcss_pkg::CFG_W-1:0]     i_cfg_data;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    mcss_pkg::t_state               o_current_state;

    // Predictor state: table, written flags, chain state, states-in-use register
    logic [mcss_pkg::PROB_BITS-1:0] prob_tbl [mcss_pkg::MAX_STATES][mcss_pkg::MAX_STATES];
    bit                             entry_set [mcss_pkg::MAX_STATES][mcss_pkg::MAX_STATES];
    mcss_pkg::t_state               chain_now;
    logic [mcss_pkg::CFG_W-1:0]     states_reg;

    mcss_pkg::t_state expected_states[$];
    int               err_count  = 0;
    int               items_sent = 0;
    bit               idle_on    = 1'b1;
    int               stall_left = 0;

    markov_chain_state_sampler uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_op            (i_op),
        .i_from_state    (i_from_state),
        .i_to_state      (i_to_state),
        .i_probability   (i_probability),
        .i_random_value  (i_random_value),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_current_state (o_current_state)
    );

    // 50 MHz clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Clamp of the register: 0 acts as 1, above the table size acts as full size
    function automatic int states_active();
        if (states_reg == '0) return 1;
        if (states_reg > mcss_pkg::MAX_STATES) return mcss_pkg::MAX_STATES;
        return int'(states_reg);
    endfunction

    // Saturating running sum of a row through column k
    function automatic int row_cdf(mcss_pkg::t_state r, int k);
        int acc;
        acc = 0;
        for (int c = 0; c <= k; c++) acc += prob_tbl[r][c];
        return (acc > PROB_FULL) ? PROB_FULL : acc;
    endfunction

    // Apply one item to the predictor, return the chain state it leaves
    function automatic mcss_pkg::t_state advance_chain(t_item it);
        int               n;
        mcss_pkg::t_state pick;
        n = states_active();
        case (it.op)
            mcss_pkg::OP_WRITE: begin
                prob_tbl[it.row][it.col]  = it.prob;
                entry_set[it.row][it.col] = 1'b1;
            end
            mcss_pkg::OP_SET: begin
                if (it.row < n) chain_now = it.row;
            end
            mcss_pkg::OP_STEP: begin
                // first column whose sum exceeds the draw, else last state in use
                pick = mcss_pkg::t_state'(n - 1);
                for (int c = n - 1; c >= 0; c--) begin
                    if (row_cdf(chain_now, c) > it.rv) pick = mcss_pkg::t_state'(c);
                end
                chain_now = pick;
            end
            default: ;
        endcase
        return chain_now;
    endfunction

    function automatic t_item item_of(logic [mcss_pkg::OP_W-1:0] op, mcss_pkg::t_state r,
                                      mcss_pkg::t_state c,
                                      logic [mcss_pkg::PROB_BITS-1:0] p,
                                      logic [mcss_pkg::PROB_BITS-1:0] v);
        t_item it;
        it.op   = op;
        it.row  = r;
        it.col  = c;
        it.prob = p;
        it.rv   = v;
        return it;
    endfunction

    task automatic report_mismatch(string what, int want, int got);
        $display("ERROR at %0t: %s expected %0d got %0d", $time, what, want, got);
        err_count++;
    endtask

    // Present one item and hold it until the transfer; called at a rising edge
    task automatic send_item(t_item it);
        mcss_pkg::t_state want;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_op           <= it.op;
        i_from_state   <= it.row;
        i_to_state     <= it.col;
        i_probability  <= it.prob;
        i_random_value <= it.rv;
        i_in_valid     <= 1'b1;
        want            = advance_chain(it);
        expected_states = {expected_states, want};
        items_sent++;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Stop sending and wait until every result has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_states.size() != 0) @(posedge i_clk);
    endtask

    // Write states in use while the block is idle
    task automatic write_states(logic [mcss_pkg::CFG_W-1:0] v);
        drain_results();
        i_cfg_data  <= v;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        states_reg = v;
        i_cfg_valid <= 1'b0;
    endtask

    // Load columns 0..n-1 of a row: sum to one, oversum, undersum or a single spike
    task automatic load_row(mcss_pkg::t_state r, int style);
        int n, left, p, spike;
        n     = states_active();
        left  = PROB_FULL;
        spike = $urandom_range(0, n - 1);
        for (int c = 0; c < n; c++) begin
            case (style)
                0: begin
                    p = (c == n - 1) ? left : $urandom_range(0, 2 * left / (n - c));
                    if (p > left) p = left;
                    left -= p;
                end
                1:       p = $urandom_range(0, PROB_MAX);
                2:       p = $urandom_range(0, PROB_FULL / (4 * n));
                default: p = (c == spike) ? PROB_MAX : 0;
            endcase
            if (p > PROB_MAX) p = PROB_MAX;
            send_item(item_of(mcss_pkg::OP_WRITE, r, mcss_pkg::t_state'(c),
                              mcss_pkg::PROB_BITS'(p), mcss_pkg::PROB_BITS'($urandom)));
        end
    endtask

    // Step from the current state; unwritten entries of its row are loaded first
    task automatic take_step(int mode);
        int n, k, v;
        n = states_active();
        for (int c = 0; c < n; c++) begin
            if (!entry_set[chain_now][c]) begin
                send_item(item_of(mcss_pkg::OP_WRITE, chain_now, mcss_pkg::t_state'(c),
                                  mcss_pkg::PROB_BITS'($urandom_range(0, 2 * PROB_FULL / n)),
                                  mcss_pkg::PROB_BITS'($urandom)));
            end
        end
        k = $urandom_range(0, n - 1);
        v = row_cdf(chain_now, k);
        case (mode)
            1:       v = 0;
            2:       v = PROB_MAX;
            3:       v = (v > PROB_MAX) ? PROB_MAX : v;          // exact tie with a running sum
            4:       v = (v == 0) ? 0 : ((v > PROB_FULL - 1) ? PROB_MAX - 1 : v - 1);
            default: v = $urandom_range(0, PROB_MAX);
        endcase
        send_item(item_of(mcss_pkg::OP_STEP, mcss_pkg::t_state'($urandom),
                          mcss_pkg::t_state'($urandom),
                          mcss_pkg::PROB_BITS'($urandom), mcss_pkg::PROB_BITS'(v)));
    endtask

    // One random phase at a given register setting
    task automatic run_random(int count, logic [mcss_pkg::CFG_W-1:0] cfg, bit idling);
        int start, sel;
        write_states(cfg);
        idle_on = idling;
        start   = items_sent;
        while (items_sent - start < count) begin
            if (idling && $urandom_range(0, 29) == 0) idle_on = !idle_on;
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
                take_step($urandom_range(0, 7));
            end else if (sel < 63) begin
                load_row(($urandom_range(0, 3) != 0) ? chain_now : mcss_pkg::t_state'($urandom),
                         $urandom_range(0, 3));
            end else if (sel < 78) begin
                send_item(item_of(mcss_pkg::OP_SET, mcss_pkg::t_state'($urandom),
                                  mcss_pkg::t_state'($urandom),
                                  mcss_pkg::PROB_BITS'($urandom),
                                  mcss_pkg::PROB_BITS'($urandom)));
            end else if (sel < 92) begin
                send_item(item_of(mcss_pkg::OP_WRITE, mcss_pkg::t_state'($urandom),
                                  mcss_pkg::t_state'($urandom),
                                  mcss_pkg::PROB_BITS'($urandom),
                                  mcss_pkg::PROB_BITS'($urandom)));
            end else begin
                send_item(item_of(OP_NOP, mcss_pkg::t_state'($urandom),
                                  mcss_pkg::t_state'($urandom),
                                  mcss_pkg::PROB_BITS'($urandom),
                                  mcss_pkg::PROB_BITS'($urandom)));
            end
        end
    endtask

    // Defaults after reset: no-op, set to the top state and back
    task automatic test_reset_defaults();
        send_item(item_of(OP_NOP, 4'hF, 4'hF, 16'hFFFF, 16'hFFFF));
        send_item(item_of(mcss_pkg::OP_SET, 4'd15, 4'h0, 16'h0000, 16'h0000));
        send_item(item_of(mcss_pkg::OP_SET, 4'd0, 4'hF, 16'hFFFF, 16'hFFFF));
        send_item(item_of(OP_NOP, 4'h0, 4'h0, 16'h0000, 16'h0000));
    endtask

    // Two-state table: ties, no column exceeding, saturation, ignored sets
    task automatic test_small_table();
        write_states(5'd2);
        send_item(item_of(mcss_pkg::OP_WRITE, 4'd0, 4'd0, 16'h0000, 16'h0000));
        send_item(item_of(mcss_pkg::OP_WRITE, 4'd0, 4'd1, 16'hFFFF, 16'h0000));
        send_item(item_of(mcss_pkg::OP_WRITE, 4'd1, 4'd0, 16'h8000, 16'h0000));
        send_item(item_of(mcss_pkg::OP_WRITE, 4'd1, 4'd1, 16'h8000, 16'h0000));
        send_item(item_of(mcss_pkg::OP_STEP, 4'd0, 4'd0, 16'h0000, 16'h0000));
        send_item(item_of(mcss_pkg::OP_STEP, 4'd0, 4'd0, 16'h0000, 16'h7FFF));
        send_item(item_of(mcss_pkg::OP_STEP, 4'd0, 4'd0, 16'h0000, 16'h0000));
        send_item(item_of(mcss_pkg::OP_STEP, 4'd0, 4'd0, 16'h0000, 16'h8000));
        send_item(item_of(mcss_pkg::OP_SET, 4'd0, 4'd0, 16'h0000, 16'h0000));
        send_item(item_of(mcss_pkg::OP_STEP, 4'd0, 4'd0, 16'h0000, 16'hFFFF));
        // both entries full scale: the sum clips at one
        send_item(item_of(mcss_pkg::OP_WRITE, 4'd1, 4'd0, 16'hFFFF, 16'h0000));
        send_item(item_of(mcss_pkg::OP_WRITE, 4'd1, 4'd1, 16'hFFFF, 16'h0000));
        send_item(item_of(mcss_pkg::OP_STEP, 4'd0, 4'd0, 16'h0000, 16'hFFFF));
        send_item(item_of(mcss_pkg::OP_SET, 4'd9, 4'd0, 16'h0000, 16'h0000));
        send_item(item_of(mcss_pkg::OP_WRITE, 4'd9, 4'd12, 16'h1234, 16'h0000));
        send_item(item_of(mcss_pkg::OP_SET, 4'd1, 4'd0, 16'h0000, 16'h0000));
    endtask

    // Register at zero acts as one state; chain state left beyond it
    task automatic test_single_state();
        write_states(5'd0);
        send_item(item_of(mcss_pkg::OP_STEP, 4'd0, 4'd0, 16'h0000, 16'h0000));
        send_item(item_of(mcss_pkg::OP_STEP, 4'd0, 4'd0, 16'h0000, 16'hFFFF));
        send_item(item_of(mcss_pkg::OP_SET, 4'd1, 4'd0, 16'h0000, 16'h0000));
    endtask

    // Random phases across register settings, idling on both sides
    task automatic test_random_phases();
        run_random(50, 5'd31, 1'b1);
        run_random(50, 5'd17, 1'b1);
        run_random(50, 5'd1, 1'b1);
        run_random(50, 5'd3, 1'b1);
        run_random(50, mcss_pkg::CFG_W'($urandom_range(2, 15)), 1'b1);
        run_random(50, 5'd8, 1'b1);
        run_random(50, 5'd16, 1'b1);
        run_random(50, 5'd0, 1'b1);
        run_random(50, mcss_pkg::CFG_W'($urandom_range(1, 16)), 1'b1);
    endtask

    // Closing stretch at full size with no idling
    task automatic test_unthrottled();
        run_random(45, 5'd16, 1'b0);
    endtask

    // Output back-pressure in random bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left  <= $urandom_range(0, 17);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Result checker: each output transfer against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_states.size() == 0) begin
                report_mismatch("result with nothing outstanding, current_state", 0,
                                o_current_state);
            end else begin
                if (o_current_state !== expected_states[0]) begin
                    report_mismatch("current_state", expected_states[0], o_current_state);
                end
                void'(expected_states.pop_front());
            end
        end
    end

    // Main sequence
    initial begin
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_op           <= OP_NOP;
        i_from_state   <= '0;
        i_to_state     <= '0;
        i_probability  <= '0;
        i_random_value <= '0;
        i_cfg_valid    <= 1'b0;
        i_cfg_data     <= '0;
        states_reg = 5'd16;
        chain_now  = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_small_table();
        test_single_state();
        test_random_phases();
        test_unthrottled();

        drain_results();
        repeat (40) @(posedge i_clk);
        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
